[design/rlfw_pkg.sv]
// rlfw_pkg: shared types, codes and constants of the recursive lock block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rlfw_pkg;

  // number of valid thread ids; ids at or above this are refused
  localparam int THREADS   = 16;
  // nesting limit, capped to what the 8-bit depth counter holds
  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_CAP_I = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;
  localparam logic [7:0] DEPTH_CAP = 8'(DEPTH_CAP_I);

  // waiter queue geometry
  localparam int QSLOTS = 16;
  localparam int QAW    = $clog2(QSLOTS);

  typedef enum logic {
    KIND_ACQUIRE = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_GRANTED     = 4'd0,
    ST_NESTED      = 4'd1,
    ST_QUEUED      = 4'd2,
    ST_REL_NESTED  = 4'd3,
    ST_FREED       = 4'd4,
    ST_HANDED_OFF  = 4'd5,
    ST_NOT_HOLDER  = 4'd6,
    ST_ALREADY_WAIT = 4'd7,
    ST_DEPTH_OVF   = 4'd8
  } status_t;

  // one request transaction
  typedef struct packed {
    logic       kind;
    logic [3:0] thread_id;
  } req_t;

  // one result transaction
  typedef struct packed {
    logic [3:0] status;
    logic [3:0] handoff_thread;
    logic       holder_present;
    logic [3:0] holder_thread;
    logic [7:0] nest_depth;
    logic [3:0] waiting_count;
  } rsp_t;

endpackage

[design/rlfw_req_if.sv]
// rlfw_req_if: valid/ready channel carrying lock requests
// depends on nothing
`timescale 1ns / 1ps

interface rlfw_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] thread_id;

  modport source (output valid, output kind, output thread_id, input ready);
  modport sink   (input valid, input kind, input thread_id, output ready);
endinterface

[design/rlfw_rsp_if.sv]
// rlfw_rsp_if: valid/ready channel carrying lock results
// depends on nothing
`timescale 1ns / 1ps

interface rlfw_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [3:0] handoff_thread;
  logic       holder_present;
  logic [3:0] holder_thread;
  logic [7:0] nest_depth;
  logic [3:0] waiting_count;

  modport source (output valid, output status, output handoff_thread,
                  output holder_present, output holder_thread,
                  output nest_depth, output waiting_count, input ready);
  modport sink   (input valid, input status, input handoff_thread,
                  input holder_present, input holder_thread,
                  input nest_depth, input waiting_count, output ready);
endinterface

[design/recursive_lock_fifo_waiters.sv]
// recursive_lock_fifo_waiters: top level of the recursive lock with waiter queue
// depends on rlfw_pkg, rlfw_req_if, rlfw_rsp_if, rlfw_in_reg, rlfw_lock_core,
// rlfw_out_reg
//
//   channel   | dir | fields
//   ----------+-----+----------------------------------------------------------
//   in_chan   | in  | kind, thread_id
//   out_chan  | out | status, handoff_thread, holder_present, holder_thread,
//             |     | nest_depth, waiting_count
//
// one request per cycle sustained while the output is not stalled; a request
// accepted on in_chan passes through the input register, then the result
// register, which presents its result on out_chan
// the lock state and queue pointers update in the cycle a request moves from
// the input register into the result register
// rst_n is synchronous and active low; it frees the lock and empties the queue
// a stalled output holds the result register, which then holds the input register
`timescale 1ns / 1ps

module recursive_lock_fifo_waiters
  import rlfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rlfw_req_if.sink   in_chan,
  rlfw_rsp_if.source out_chan
);

  logic req_valid;
  req_t req;
  rsp_t rsp;
  logic out_free;
  logic advance;

  // a request moves on when the result register has room
  assign advance = req_valid && out_free;

  rlfw_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  rlfw_lock_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req),
    .rsp     (rsp)
  );

  rlfw_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .rsp      (rsp),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule

[design/rlfw_in_reg.sv]
// rlfw_in_reg: input register stage for request transactions
// depends on rlfw_pkg and rlfw_req_if
`timescale 1ns / 1ps

module rlfw_in_reg
  import rlfw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  rlfw_req_if.sink         in_chan,
  input  logic             advance,
  output logic             req_valid,
  output req_t             req
);

  logic valid_r, valid_nxt;
  req_t req_r;

  // take a new transaction when empty or when the held one moves on
  assign in_chan.ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_chan.ready) begin
      valid_nxt = in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      req_r.kind      <= in_chan.kind;
      req_r.thread_id <= in_chan.thread_id;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

[design/rlfw_lock_core.sv]
// rlfw_lock_core: lock state, waiter queue and the per-request decision
// depends on rlfw_pkg
`timescale 1ns / 1ps

module rlfw_lock_core
  import rlfw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  req_t req,
  output rsp_t rsp
);

  logic              owner_valid_r, owner_valid_nxt;
  logic [3:0]        owner_id_r, owner_id_nxt;
  logic [7:0]        depth_r, depth_nxt;
  logic [QAW-1:0]    head_r, head_nxt;
  logic [QAW-1:0]    tail_r, tail_nxt;
  logic [QAW:0]      fill_r, fill_nxt;
  logic [15:0]       wmap_r, wmap_nxt;
  logic [3:0]        wait_fifo [QSLOTS];

  logic              tid_ok;
  logic              is_owner;
  logic              push;
  logic [3:0]        head_tid;
  logic [3:0]        status;
  logic [3:0]        handoff;

  assign tid_ok   = 32'(req.thread_id) < THREADS;
  assign is_owner = owner_valid_r && (owner_id_r == req.thread_id);
  assign head_tid = wait_fifo[head_r];

  // request decision
  always_comb begin
    owner_valid_nxt = owner_valid_r;
    owner_id_nxt    = owner_id_r;
    depth_nxt       = depth_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    fill_nxt        = fill_r;
    wmap_nxt        = wmap_r;
    push            = 1'b0;
    handoff         = 4'd0;
    status          = ST_NOT_HOLDER;
    if (!tid_ok) begin
      status = ST_NOT_HOLDER;
    end else if (req.kind == KIND_ACQUIRE) begin
      if (is_owner) begin
        if (depth_r >= DEPTH_CAP) begin
          status = ST_DEPTH_OVF;
        end else begin
          depth_nxt = depth_r + 8'd1;
          status    = ST_NESTED;
        end
      end else if (!owner_valid_r) begin
        owner_valid_nxt = 1'b1;
        owner_id_nxt    = req.thread_id;
        depth_nxt       = 8'd1;
        status          = ST_GRANTED;
      end else if (wmap_r[req.thread_id] || fill_r[QAW]) begin
        status = ST_ALREADY_WAIT;
      end else begin
        push                    = 1'b1;
        tail_nxt                = tail_r + 1'b1;
        fill_nxt                = fill_r + 1'b1;
        wmap_nxt[req.thread_id] = 1'b1;
        status                  = ST_QUEUED;
      end
    end else begin
      if (!is_owner) begin
        status = ST_NOT_HOLDER;
      end else if (depth_r > 8'd1) begin
        depth_nxt = depth_r - 8'd1;
        status    = ST_REL_NESTED;
      end else if (fill_r == '0) begin
        owner_valid_nxt = 1'b0;
        owner_id_nxt    = 4'd0;
        depth_nxt       = 8'd0;
        status          = ST_FREED;
      end else begin
        // direct handoff to the head waiter
        head_nxt           = head_r + 1'b1;
        fill_nxt           = fill_r - 1'b1;
        wmap_nxt[head_tid] = 1'b0;
        owner_valid_nxt    = 1'b1;
        owner_id_nxt       = head_tid;
        depth_nxt          = 8'd1;
        handoff            = head_tid;
        status             = ST_HANDED_OFF;
      end
    end
  end

  // result fields reflect the state after this request
  always_comb begin
    rsp.status         = status;
    rsp.handoff_thread = handoff;
    rsp.holder_present = owner_valid_nxt;
    rsp.holder_thread  = owner_valid_nxt ? owner_id_nxt : 4'd0;
    rsp.nest_depth     = depth_nxt;
    rsp.waiting_count  = fill_nxt[3:0];
  end

  // lock state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_valid_r <= 1'b0;
      owner_id_r    <= 4'd0;
      depth_r       <= 8'd0;
      head_r        <= '0;
      tail_r        <= '0;
      fill_r        <= '0;
      wmap_r        <= 16'd0;
    end else if (advance) begin
      owner_valid_r <= owner_valid_nxt;
      owner_id_r    <= owner_id_nxt;
      depth_r       <= depth_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      fill_r        <= fill_nxt;
      wmap_r        <= wmap_nxt;
    end
  end

  // waiter queue storage
  always_ff @(posedge clk) begin
    if (advance && push) begin
      wait_fifo[tail_r] <= req.thread_id;
    end
  end

endmodule

[design/rlfw_out_reg.sv]
// rlfw_out_reg: result register driving the output channel
// depends on rlfw_pkg and rlfw_rsp_if
`timescale 1ns / 1ps

module rlfw_out_reg
  import rlfw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  rsp_t      rsp,
  output logic      out_free,
  rlfw_rsp_if.source out_chan
);

  logic valid_r, valid_nxt;
  rsp_t rsp_r;

  // room for a new result when empty or being drained this cycle
  assign out_free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_free) begin
      valid_nxt = advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.status         = rsp_r.status;
  assign out_chan.handoff_thread = rsp_r.handoff_thread;
  assign out_chan.holder_present = rsp_r.holder_present;
  assign out_chan.holder_thread  = rsp_r.holder_thread;
  assign out_chan.nest_depth     = rsp_r.nest_depth;
  assign out_chan.waiting_count  = rsp_r.waiting_count;

endmodule

[dv/recursive_lock_fifo_waiters_tb.sv]
// recursive_lock_fifo_waiters_tb: self-checking bench for the recursive lock with waiter queue
// drives acquire/release transactions, checks each result against a shadow lock or typed row
// depends on rlfw_pkg, rlfw_req_if, rlfw_rsp_if and recursive_lock_fifo_waiters
`timescale 1ns / 1ps

module recursive_lock_fifo_waiters_tb;
  import rlfw_pkg::*;

  localparam int RANDOM_ITEMS   = 1110;
  localparam int SEGMENT_ITEMS  = 30;
  localparam int CALM_ITEMS     = 150;
  localparam int PRESSURE_AT    = 900;
  localparam int PRESSURE_HOLD  = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SCRIPT_ROWS    = 24;

  // traffic mixes for the random segments
  typedef enum int {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN,
    MIX_NOISE
  } mix_t;

  // one row of the directed script; exact rows carry a typed-in result
  typedef struct packed {
    logic       exact;
    kind_t      kind;
    logic [3:0] tid;
    rsp_t       rsp;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{1'b1, KIND_RELEASE,  4'd0,  '{ST_NOT_HOLDER,   4'd0,  1'b0, 4'd0,  8'd0, 4'd0}},
    '{1'b1, KIND_ACQUIRE,  4'd0,  '{ST_GRANTED,      4'd0,  1'b1, 4'd0,  8'd1, 4'd0}},
    '{1'b1, KIND_ACQUIRE,  4'd0,  '{ST_NESTED,       4'd0,  1'b1, 4'd0,  8'd2, 4'd0}},
    '{1'b1, KIND_ACQUIRE,  4'd15, '{ST_QUEUED,       4'd0,  1'b1, 4'd0,  8'd2, 4'd1}},
    '{1'b1, KIND_ACQUIRE,  4'd15, '{ST_ALREADY_WAIT, 4'd0,  1'b1, 4'd0,  8'd2, 4'd1}},
    '{1'b1, KIND_RELEASE,  4'd15, '{ST_NOT_HOLDER,   4'd0,  1'b1, 4'd0,  8'd2, 4'd1}},
    '{1'b1, KIND_ACQUIRE,  4'd5,  '{ST_QUEUED,       4'd0,  1'b1, 4'd0,  8'd2, 4'd2}},
    '{1'b1, KIND_RELEASE,  4'd0,  '{ST_REL_NESTED,   4'd0,  1'b1, 4'd0,  8'd1, 4'd2}},
    '{1'b1, KIND_RELEASE,  4'd0,  '{ST_HANDED_OFF,   4'd15, 1'b1, 4'd15, 8'd1, 4'd1}},
    '{1'b1, KIND_ACQUIRE,  4'd15, '{ST_NESTED,       4'd0,  1'b1, 4'd15, 8'd2, 4'd1}},
    '{1'b1, KIND_RELEASE,  4'd15, '{ST_REL_NESTED,   4'd0,  1'b1, 4'd15, 8'd1, 4'd1}},
    '{1'b1, KIND_RELEASE,  4'd15, '{ST_HANDED_OFF,   4'd5,  1'b1, 4'd5,  8'd1, 4'd0}},
    '{1'b1, KIND_RELEASE,  4'd5,  '{ST_FREED,        4'd0,  1'b0, 4'd0,  8'd0, 4'd0}},
    '{1'b1, KIND_RELEASE,  4'd5,  '{ST_NOT_HOLDER,   4'd0,  1'b0, 4'd0,  8'd0, 4'd0}},
    '{1'b0, KIND_ACQUIRE,  4'd10, '0},
    '{1'b0, KIND_ACQUIRE,  4'd3,  '0},
    '{1'b0, KIND_ACQUIRE,  4'd12, '0},
    '{1'b0, KIND_ACQUIRE,  4'd3,  '0},
    '{1'b0, KIND_ACQUIRE,  4'd10, '0},
    '{1'b0, KIND_RELEASE,  4'd10, '0},
    '{1'b0, KIND_RELEASE,  4'd10, '0},
    '{1'b0, KIND_RELEASE,  4'd12, '0},
    '{1'b0, KIND_RELEASE,  4'd3,  '0},
    '{1'b0, KIND_RELEASE,  4'd12, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  rlfw_req_if in_chan ();
  rlfw_rsp_if out_chan ();

  recursive_lock_fifo_waiters uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // shadow lock state
  bit          lk_held;
  logic [3:0]  lk_holder;
  logic [7:0]  lk_depth;
  logic [3:0]  lk_waiters [$];
  logic [15:0] lk_waitmap;

  rsp_t pending_results [$];
  int   items_sent;
  int   mismatches;
  int   quiet_cycles;
  bit   calm;
  bit   pressure_done;

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // advance the shadow lock by one request and return the result it gives
  function automatic rsp_t predict_lock(input kind_t k, input logic [3:0] tid);
    rsp_t       r;
    logic [3:0] nxt;
    r = '0;
    if (int'(tid) >= THREADS) begin
      r.status = ST_NOT_HOLDER;
    end else if (k == KIND_ACQUIRE) begin
      if (lk_held && lk_holder == tid) begin
        if (lk_depth >= DEPTH_CAP) begin
          r.status = ST_DEPTH_OVF;
        end else begin
          lk_depth = lk_depth + 8'd1;
          r.status = ST_NESTED;
        end
      end else if (!lk_held) begin
        lk_held   = 1'b1;
        lk_holder = tid;
        lk_depth  = 8'd1;
        r.status  = ST_GRANTED;
      end else if (lk_waitmap[tid] || lk_waiters.size() >= QSLOTS) begin
        r.status = ST_ALREADY_WAIT;
      end else begin
        lk_waiters.push_back(tid);
        lk_waitmap[tid] = 1'b1;
        r.status = ST_QUEUED;
      end
    end else begin
      if (!lk_held || lk_holder != tid) begin
        r.status = ST_NOT_HOLDER;
      end else if (lk_depth > 8'd1) begin
        lk_depth = lk_depth - 8'd1;
        r.status = ST_REL_NESTED;
      end else if (lk_waiters.size() == 0) begin
        lk_held   = 1'b0;
        lk_holder = '0;
        lk_depth  = '0;
        r.status  = ST_FREED;
      end else begin
        // direct handoff to the oldest waiter
        nxt = lk_waiters.pop_front();
        lk_waitmap[nxt] = 1'b0;
        lk_holder = nxt;
        lk_depth  = 8'd1;
        r.handoff_thread = nxt;
        r.status  = ST_HANDED_OFF;
      end
    end
    r.holder_present = lk_held;
    r.holder_thread  = lk_held ? lk_holder : 4'd0;
    r.nest_depth     = lk_depth;
    r.waiting_count  = 4'(lk_waiters.size());
    return r;
  endfunction

  // offer one request, wait for acceptance, record its expected result
  task automatic offer(input kind_t k, input logic [3:0] tid, input logic exact,
                       input rsp_t typed_rsp);
    rsp_t predicted;
    in_chan.valid     <= 1'b1;
    in_chan.kind      <= k;
    in_chan.thread_id <= tid;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predicted = predict_lock(k, tid);
    pending_results.push_back(exact ? typed_rsp : predicted);
    items_sent++;
    // occasional idle burst on the request side
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // choose a request shaped by the current lock state
  task automatic pick_request(input mix_t mix, output kind_t k, output logic [3:0] tid);
    int         roll;
    int         noise_pct;
    int         queue_pct;
    int         rel_pct;
    logic [3:0] start;
    logic [3:0] cand;
    bit         found;
    noise_pct = (mix == MIX_NOISE) ? 60 : 10;
    queue_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 10 : 40;
    rel_pct   = (mix == MIX_FILL) ? 20 : (mix == MIX_DRAIN) ? 75 : 40;
    roll      = $urandom_range(0, 99);
    k         = KIND_ACQUIRE;
    tid       = 4'($urandom_range(0, 15));
    if (roll < noise_pct) begin
      k = kind_t'($urandom_range(0, 1));
    end else if (lk_held) begin
      roll = $urandom_range(0, 99);
      if (roll < rel_pct) begin
        k   = KIND_RELEASE;
        tid = lk_holder;
      end else begin
        // a fresh waiter if one is left and the roll falls in the queue share, else a nested acquire
        tid   = lk_holder;
        found = 1'b0;
        start = 4'($urandom_range(0, 15));
        if (roll < rel_pct + queue_pct) begin
          for (int i = 0; i < 16; i++) begin
            cand = start + 4'(i);
            if (!found && cand != lk_holder && !lk_waitmap[cand]) begin
              tid   = cand;
              found = 1'b1;
            end
          end
        end
      end
    end
  endtask

  // report one field mismatch, detail only for the first few
  task automatic note_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result status", 8'd0, 8'(out_chan.status));
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status)
          note_mismatch("status", 8'(want.status), 8'(out_chan.status));
        if (out_chan.handoff_thread !== want.handoff_thread)
          note_mismatch("handoff_thread", 8'(want.handoff_thread), 8'(out_chan.handoff_thread));
        if (out_chan.holder_present !== want.holder_present)
          note_mismatch("holder_present", 8'(want.holder_present), 8'(out_chan.holder_present));
        if (out_chan.holder_thread !== want.holder_thread)
          note_mismatch("holder_thread", 8'(want.holder_thread), 8'(out_chan.holder_thread));
        if (out_chan.nest_depth !== want.nest_depth)
          note_mismatch("nest_depth", want.nest_depth, out_chan.nest_depth);
        if (out_chan.waiting_count !== want.waiting_count)
          note_mismatch("waiting_count", 8'(want.waiting_count), 8'(out_chan.waiting_count));
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side ready: random stalls plus one long hold-off
  initial begin
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (!pressure_done && items_sent >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    kind_t      k;
    logic [3:0] tid;
    logic [3:0] deep_tid;
    logic [3:0] waiter_tid;
    mix_t       mix;
    lk_held    = 1'b0;
    lk_holder  = '0;
    lk_depth   = '0;
    lk_waitmap = '0;
    mix = MIX_BALANCED;

    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.kind      <= KIND_ACQUIRE;
    in_chan.thread_id <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed script
    foreach (SCRIPT[i])
      offer(SCRIPT[i].kind, SCRIPT[i].tid, SCRIPT[i].exact, SCRIPT[i].rsp);

    // nest one thread up to the depth limit and past it, with a waiter queued
    deep_tid   = 4'($urandom_range(0, 15));
    waiter_tid = deep_tid ^ 4'($urandom_range(1, 15));
    offer(KIND_ACQUIRE, deep_tid, 1'b0, '0);
    offer(KIND_ACQUIRE, waiter_tid, 1'b0, '0);
    repeat (DEPTH_CAP_I) offer(KIND_ACQUIRE, deep_tid, 1'b0, '0);
    repeat (DEPTH_CAP_I) offer(KIND_RELEASE, deep_tid, 1'b0, '0);
    offer(KIND_RELEASE, waiter_tid, 1'b0, '0);

    // random segments, the tail without idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0)
        mix = mix_t'($urandom_range(0, 3));
      if (n == RANDOM_ITEMS - CALM_ITEMS)
        calm = 1'b1;
      pick_request(mix, k, tid);
      offer(k, tid, 1'b0, '0);
    end
    in_chan.valid <= 1'b0;

    // wait out every result, then the pipeline latency
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/rlfw_pkg.sv
design/rlfw_req_if.sv
design/rlfw_rsp_if.sv
design/rlfw_in_reg.sv
design/rlfw_lock_core.sv
design/rlfw_out_reg.sv
design/recursive_lock_fifo_waiters.sv
dv/recursive_lock_fifo_waiters_tb.sv
